// ===== src/rrsm_pkg.sv =====
// Shared types and constants of the registration retry controller.
// Used by rrsm_front, rrsm_back and the top level; depends on nothing.
package rrsm_pkg;

	// Low bits of now_ms that take part in deadline arithmetic
	localparam int TIME_BITS = 40;
	localparam int NOW_W     = 40;

	localparam int EVQ_DEPTH = 4;
	localparam int EVQ_AW    = $clog2(EVQ_DEPTH);
	localparam int RESQ_DEPTH = 2;
	localparam int RESQ_AW    = $clog2(RESQ_DEPTH);

	// Configuration register indexes
	localparam logic REG_RETRY_LIMIT = 1'b0;
	localparam logic REG_STEP_TMO    = 1'b1;

	localparam logic [3:0]  RETRY_LIMIT_RST = 4'd2;
	localparam logic [15:0] STEP_TMO_RST    = 16'd1200;

	// Input opcodes
	localparam logic [3:0] OP_INIT     = 4'd0;
	localparam logic [3:0] OP_RADIO    = 4'd1;
	localparam logic [3:0] OP_SIM      = 4'd2;
	localparam logic [3:0] OP_REG      = 4'd3;
	localparam logic [3:0] OP_MOBILITY = 4'd4;
	localparam logic [3:0] OP_PERIODIC = 4'd5;
	localparam logic [3:0] OP_CELL     = 4'd6;
	localparam logic [3:0] OP_FORCE    = 4'd7;
	localparam logic [3:0] OP_ACCEPT   = 4'd8;
	localparam logic [3:0] OP_REJECT   = 4'd9;
	localparam logic [3:0] OP_TICK     = 4'd10;

	// Reject causes
	localparam logic [2:0] RC_NONE       = 3'd0;
	localparam logic [2:0] RC_CONGESTION = 3'd1;
	localparam logic [2:0] RC_ILLEGAL_UE = 3'd2;
	localparam logic [2:0] RC_PLMN_NA    = 3'd3;
	localparam logic [2:0] RC_TA_NA      = 3'd4;

	// Registration type and trigger
	localparam logic       RT_INITIAL  = 1'b0;
	localparam logic       RT_MOBILITY = 1'b1;
	localparam logic [1:0] TRIG_EXPLICIT = 2'd0;
	localparam logic [1:0] TRIG_MOBILITY = 2'd1;
	localparam logic [1:0] TRIG_PERIODIC = 2'd2;

	// Procedure steps
	localparam logic [1:0] STEP_NONE = 2'd0;
	localparam logic [1:0] STEP_CELL = 2'd1;
	localparam logic [1:0] STEP_RESP = 2'd2;

	typedef enum logic [3:0] {
		EV_NOP,
		EV_INIT,
		EV_RADIO,
		EV_SIM,
		EV_REQ,
		EV_CELL,
		EV_FORCE,
		EV_ACCEPT,
		EV_REJECT,
		EV_TICK
	} ev_kind_t;

	typedef enum logic [5:0] {
		ST_OFF    = 6'b000001,
		ST_SIMNR  = 6'b000010,
		ST_DEREG  = 6'b000100,
		ST_SEARCH = 6'b001000,
		ST_REGING = 6'b010000,
		ST_REGD   = 6'b100000
	} mm_st_t;

	typedef enum logic [3:0] {
		C_NONE      = 4'd0,
		C_RADIO_OFF = 4'd1,
		C_POWER_ON  = 4'd2,
		C_SIM_NR    = 4'd3,
		C_SIM_READY = 4'd4,
		C_REQUESTED = 4'd5,
		C_ACCEPTED  = 4'd6,
		C_REJECTED  = 4'd7,
		C_TIMEOUT   = 4'd8,
		C_RETRY     = 4'd9
	} cause_t;

	// Classified event handed from front to back
	typedef struct packed {
		ev_kind_t               kind;
		logic                   flag_on;
		logic                   sim_in;
		logic                   submitted;
		logic                   non3gpp;
		logic                   rc_perm;
		logic                   rtype;
		logic [1:0]             rtrig;
		logic [TIME_BITS-1:0]   now;
		logic [TIME_BITS:0]     now_plus;
	} evt_t;

	// Status snapshot of one event
	typedef struct packed {
		logic [2:0]  mm_state;
		logic        in_procedure;
		logic [1:0]  step_code;
		logic [3:0]  trans_cause;
		logic        reject_permanent;
		logic [3:0]  retry_cnt;
		logic [15:0] attempt_number;
		logic        request_pending;
		logic        reg_kind;
		logic [1:0]  reg_trigger;
		logic        request_sent;
	} res_t;

endpackage

// ===== src/registration_retry_state_machine_core.sv =====
// Top level of the registration retry controller.
// Instantiates rrsm_front and rrsm_back; uses rrsm_pkg.

// Takes one event per clock while full is low and returns one status
// snapshot per event, in order. An event is written into the event queue,
// then applied to the state, and its snapshot is written into the result
// queue, where it is visible (empty low), once the result queue has room.
// The state update is combinational compare and add logic, so with pop
// held the block sustains one event per cycle; a 4-entry event queue and
// a 2-entry result queue absorb stalls on either side. Configuration writes
// take effect at once and are meant for times when no event is in flight.
module registration_retry_state_machine_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr_en,
	input  logic                        wr_index,
	input  logic [15:0]                 wr_data,
	input  logic                        push,
	output logic                        full,
	input  logic [3:0]                  opcode,
	input  logic                        flag_on,
	input  logic                        sim_in,
	input  logic                        was_submitted,
	input  logic                        accept_non3gpp,
	input  logic [2:0]                  rej_cause,
	input  logic [rrsm_pkg::NOW_W-1:0]  now_ms,
	output logic                        empty,
	input  logic                        pop,
	output logic [2:0]                  mm_state,
	output logic                        in_procedure,
	output logic [1:0]                  step_code,
	output logic [3:0]                  trans_cause,
	output logic                        reject_permanent,
	output logic [3:0]                  retry_cnt,
	output logic [15:0]                 attempt_number,
	output logic                        request_pending,
	output logic                        reg_kind,
	output logic [1:0]                  reg_trigger,
	output logic                        request_sent
);
	import rrsm_pkg::*;

	logic       evq_empty;
	logic       evq_pop;
	evt_t       evq_head;
	logic [3:0] retry_limit;
	res_t       res_head;

	rrsm_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.wr_en          (wr_en),
		.wr_index       (wr_index),
		.wr_data        (wr_data),
		.push           (push),
		.full           (full),
		.opcode         (opcode),
		.flag_on        (flag_on),
		.sim_in         (sim_in),
		.was_submitted  (was_submitted),
		.accept_non3gpp (accept_non3gpp),
		.rej_cause      (rej_cause),
		.now_ms         (now_ms),
		.retry_limit    (retry_limit),
		.evq_empty      (evq_empty),
		.evq_head       (evq_head),
		.evq_pop        (evq_pop)
	);

	rrsm_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.retry_limit (retry_limit),
		.evq_empty   (evq_empty),
		.evq_head    (evq_head),
		.evq_pop     (evq_pop),
		.empty       (empty),
		.pop         (pop),
		.res_head    (res_head)
	);

	assign mm_state         = res_head.mm_state;
	assign in_procedure     = res_head.in_procedure;
	assign step_code        = res_head.step_code;
	assign trans_cause      = res_head.trans_cause;
	assign reject_permanent = res_head.reject_permanent;
	assign retry_cnt        = res_head.retry_cnt;
	assign attempt_number   = res_head.attempt_number;
	assign request_pending  = res_head.request_pending;
	assign reg_kind         = res_head.reg_kind;
	assign reg_trigger      = res_head.reg_trigger;
	assign request_sent     = res_head.request_sent;

endmodule

// ===== src/rrsm_front.sv =====
// Front end: configuration registers, event classification and the event queue.
// Depends on rrsm_pkg; feeds rrsm_back.
module rrsm_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic                           wr_index,
	input  logic [15:0]                    wr_data,
	input  logic                           push,
	output logic                           full,
	input  logic [3:0]                     opcode,
	input  logic                           flag_on,
	input  logic                           sim_in,
	input  logic                           was_submitted,
	input  logic                           accept_non3gpp,
	input  logic [2:0]                     rej_cause,
	input  logic [rrsm_pkg::NOW_W-1:0]     now_ms,
	output logic [3:0]                     retry_limit,
	output logic                           evq_empty,
	output rrsm_pkg::evt_t                 evq_head,
	input  logic                           evq_pop
);
	import rrsm_pkg::*;

	logic [3:0]           retry_limit_q;
	logic [15:0]          step_tmo_q;
	logic [TIME_BITS-1:0] now_t;
	evt_t                 evt;
	logic                 wr_ok;
	evt_t                 evq_q [EVQ_DEPTH];
	logic [EVQ_AW-1:0]    wr_ptr_q;
	logic [EVQ_AW-1:0]    rd_ptr_q;
	logic [EVQ_AW:0]      cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retry_limit_q <= RETRY_LIMIT_RST;
			step_tmo_q    <= STEP_TMO_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_RETRY_LIMIT: retry_limit_q <= wr_data[3:0];
				REG_STEP_TMO:    step_tmo_q    <= wr_data;
				default:         ;
			endcase
		end
	end

	assign retry_limit = retry_limit_q;
	assign now_t       = TIME_BITS'(now_ms);

	// Classify the opcode and precompute the candidate deadline
	always_comb begin
		evt.flag_on     = flag_on;
		evt.sim_in      = sim_in;
		evt.submitted   = was_submitted;
		evt.non3gpp     = accept_non3gpp;
		evt.rc_perm     = (rej_cause == RC_ILLEGAL_UE) || (rej_cause == RC_PLMN_NA)
			|| (rej_cause == RC_TA_NA);
		evt.now         = now_t;
		evt.now_plus    = (TIME_BITS + 1)'(now_t) + (TIME_BITS + 1)'(step_tmo_q);
		evt.rtype       = RT_INITIAL;
		evt.rtrig       = TRIG_EXPLICIT;
		unique case (opcode)
			OP_INIT:     evt.kind = EV_INIT;
			OP_RADIO:    evt.kind = EV_RADIO;
			OP_SIM:      evt.kind = EV_SIM;
			OP_REG:      evt.kind = EV_REQ;
			OP_MOBILITY: begin
				evt.kind  = EV_REQ;
				evt.rtype = RT_MOBILITY;
				evt.rtrig = TRIG_MOBILITY;
			end
			OP_PERIODIC: begin
				evt.kind  = EV_REQ;
				evt.rtype = RT_MOBILITY;
				evt.rtrig = TRIG_PERIODIC;
			end
			OP_CELL:     evt.kind = EV_CELL;
			OP_FORCE:    evt.kind = EV_FORCE;
			OP_ACCEPT:   evt.kind = EV_ACCEPT;
			OP_REJECT:   evt.kind = EV_REJECT;
			OP_TICK:     evt.kind = EV_TICK;
			default:     evt.kind = EV_NOP;
		endcase
	end

	assign full      = (cnt_q == (EVQ_AW + 1)'(EVQ_DEPTH));
	assign evq_empty = (cnt_q == '0);
	assign wr_ok     = push && !full;
	assign evq_head  = evq_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_ok)
			evq_q[wr_ptr_q] <= evt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_ok)
				wr_ptr_q <= (wr_ptr_q == EVQ_AW'(EVQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (evq_pop)
				rd_ptr_q <= (rd_ptr_q == EVQ_AW'(EVQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (wr_ok && !evq_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (!wr_ok && evq_pop)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	a_evq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (EVQ_AW + 1)'(EVQ_DEPTH))
		else $error("event queue count over depth");

	a_evq_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		evq_pop |-> !evq_empty)
		else $error("event queue popped while empty");

endmodule

// ===== src/rrsm_back.sv =====
// Back end: registration state, one event applied per cycle while the result queue has room.
// Depends on rrsm_pkg; takes classified events from rrsm_front.
module rrsm_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [3:0]      retry_limit,
	input  logic            evq_empty,
	input  rrsm_pkg::evt_t  evq_head,
	output logic            evq_pop,
	output logic            empty,
	input  logic            pop,
	output rrsm_pkg::res_t  res_head
);
	import rrsm_pkg::*;

	typedef struct packed {
		mm_st_t             st;
		logic               proc;
		logic [1:0]         step;
		cause_t             cause;
		logic               perm;
		logic [3:0]         retries;
		logic [15:0]        attempt;
		logic               req;
		logic               ptype;
		logic [1:0]         ptrig;
		logic [TIME_BITS:0] deadline;
	} ctx_t;

	ctx_t                cur_q;
	ctx_t                nxt;
	logic                sent;
	logic [TIME_BITS:0]  dl;
	res_t                res;
	logic                res_space;
	logic                pop_ok;
	res_t                resq_q [RESQ_DEPTH];
	logic [RESQ_AW-1:0]  wr_ptr_q;
	logic [RESQ_AW-1:0]  rd_ptr_q;
	logic [RESQ_AW:0]    cnt_q;

	function automatic ctx_t go_dereg(ctx_t s, cause_t c);
		ctx_t r;
		r          = s;
		r.st       = ST_DEREG;
		r.proc     = 1'b0;
		r.step     = STEP_NONE;
		r.cause    = c;
		r.req      = 1'b0;
		r.retries  = '0;
		r.deadline = '0;
		return r;
	endfunction

	function automatic ctx_t clear_proc(ctx_t s, mm_st_t st, cause_t c);
		ctx_t r;
		r      = go_dereg(s, c);
		r.st   = st;
		r.perm = 1'b0;
		return r;
	endfunction

	function automatic ctx_t go_retry(ctx_t s, logic [TIME_BITS:0] next);
		ctx_t r;
		r          = s;
		r.retries  = s.retries + 1'b1;
		r.attempt  = s.attempt + 1'b1;
		r.st       = ST_SEARCH;
		r.proc     = 1'b1;
		r.step     = STEP_CELL;
		r.cause    = C_RETRY;
		r.perm     = 1'b0;
		r.deadline = next;
		return r;
	endfunction

	function automatic logic [2:0] state_code(mm_st_t st);
		logic [2:0] c;
		unique case (st)
			ST_OFF:    c = 3'd0;
			ST_SIMNR:  c = 3'd1;
			ST_DEREG:  c = 3'd2;
			ST_SEARCH: c = 3'd3;
			ST_REGING: c = 3'd4;
			ST_REGD:   c = 3'd5;
			default:   c = 3'd0;
		endcase
		return c;
	endfunction

	// Room in the result queue, counting a transfer out in this cycle
	assign pop_ok    = pop && !empty;
	assign res_space = (cnt_q != (RESQ_AW + 1)'(RESQ_DEPTH)) || pop_ok;
	assign evq_pop   = !evq_empty && res_space;

	always_comb begin
		nxt  = cur_q;
		sent = 1'b0;
		dl   = (cur_q.deadline == '0) ? evq_head.now_plus : cur_q.deadline;
		unique case (evq_head.kind)
			EV_INIT: begin
				nxt       = clear_proc(cur_q, ST_OFF, C_RADIO_OFF);
				nxt.ptype = RT_INITIAL;
				nxt.ptrig = TRIG_EXPLICIT;
				if (evq_head.flag_on) begin
					nxt.st    = evq_head.sim_in ? ST_DEREG : ST_SIMNR;
					nxt.cause = evq_head.sim_in ? C_POWER_ON : C_SIM_NR;
				end
			end
			EV_RADIO: begin
				if (!evq_head.flag_on)
					nxt = clear_proc(cur_q, ST_OFF, C_RADIO_OFF);
				else if (cur_q.st != ST_SIMNR) begin
					nxt      = go_dereg(cur_q, C_POWER_ON);
					nxt.perm = 1'b0;
				end
			end
			EV_SIM: begin
				if (!evq_head.flag_on)
					nxt = clear_proc(cur_q, ST_SIMNR, C_SIM_NR);
				else begin
					if (cur_q.st == ST_SIMNR)
						nxt.st = ST_DEREG;
					nxt.cause = C_SIM_READY;
				end
			end
			EV_REQ: begin
				nxt.req     = 1'b1;
				nxt.retries = '0;
				nxt.ptype   = evq_head.rtype;
				nxt.ptrig   = evq_head.rtrig;
				if (cur_q.st == ST_DEREG || cur_q.st == ST_REGD) begin
					nxt.attempt  = cur_q.attempt + 1'b1;
					nxt.st       = ST_SEARCH;
					nxt.proc     = 1'b1;
					nxt.step     = STEP_CELL;
					nxt.cause    = C_REQUESTED;
					nxt.perm     = 1'b0;
					nxt.deadline = '0;
				end
			end
			EV_CELL: begin
				if (cur_q.st == ST_SEARCH && cur_q.req && cur_q.step == STEP_CELL) begin
					sent = 1'b1;
					if (evq_head.submitted && !evq_head.non3gpp) begin
						nxt.perm     = 1'b0;
						nxt.st       = ST_REGING;
						nxt.step     = STEP_RESP;
						nxt.deadline = '0;
					end else begin
						// non-3GPP accept counts as a permanent reject; an unsent request takes it from the cause
						nxt      = go_dereg(cur_q, C_REJECTED);
						nxt.perm = evq_head.submitted ? 1'b1 : evq_head.rc_perm;
					end
				end
			end
			EV_FORCE: begin
				nxt.st       = ST_REGING;
				nxt.step     = STEP_RESP;
				nxt.deadline = '0;
			end
			EV_ACCEPT: begin
				if (cur_q.st == ST_REGING && cur_q.req)
					nxt = clear_proc(cur_q, ST_REGD, C_ACCEPTED);
			end
			EV_REJECT: begin
				if (cur_q.st == ST_REGING && cur_q.req) begin
					if (cur_q.proc && cur_q.step == STEP_RESP && !evq_head.rc_perm
						&& cur_q.retries < retry_limit)
						nxt = go_retry(cur_q, '0);
					else begin
						nxt      = go_dereg(cur_q, C_REJECTED);
						nxt.perm = evq_head.rc_perm;
					end
				end
			end
			EV_TICK: begin
				if ((cur_q.st == ST_SEARCH && cur_q.req && cur_q.step == STEP_CELL)
					|| (cur_q.st == ST_REGING && cur_q.req && cur_q.step == STEP_RESP)) begin
					nxt.deadline = dl;
					if ((TIME_BITS + 1)'(evq_head.now) >= dl) begin
						if (cur_q.retries < retry_limit)
							nxt = go_retry(cur_q, evq_head.now_plus);
						else begin
							nxt      = go_dereg(cur_q, C_TIMEOUT);
							nxt.perm = 1'b0;
						end
					end
				end else begin
					if (cur_q.st != ST_REGING && cur_q.st != ST_SEARCH) begin
						nxt.proc = 1'b0;
						nxt.step = STEP_NONE;
					end
					nxt.deadline = '0;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		res.mm_state         = state_code(nxt.st);
		res.in_procedure     = nxt.proc;
		res.step_code        = nxt.step;
		res.trans_cause      = nxt.cause;
		res.reject_permanent = nxt.perm;
		res.retry_cnt        = nxt.retries;
		res.attempt_number   = nxt.attempt;
		res.request_pending  = nxt.req;
		res.reg_kind         = nxt.ptype;
		res.reg_trigger      = nxt.ptrig;
		res.request_sent     = sent;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q.st       <= ST_OFF;
			cur_q.proc     <= 1'b0;
			cur_q.step     <= STEP_NONE;
			cur_q.cause    <= C_RADIO_OFF;
			cur_q.perm     <= 1'b0;
			cur_q.retries  <= '0;
			cur_q.attempt  <= '0;
			cur_q.req      <= 1'b0;
			cur_q.ptype    <= RT_INITIAL;
			cur_q.ptrig    <= TRIG_EXPLICIT;
			cur_q.deadline <= '0;
		end else if (evq_pop) begin
			cur_q <= nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (evq_pop)
			resq_q[wr_ptr_q] <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (evq_pop)
				wr_ptr_q <= (wr_ptr_q == RESQ_AW'(RESQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop_ok)
				rd_ptr_q <= (rd_ptr_q == RESQ_AW'(RESQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (evq_pop && !pop_ok)
				cnt_q <= cnt_q + 1'b1;
			else if (!evq_pop && pop_ok)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	assign empty    = (cnt_q == '0);
	assign res_head = resq_q[rd_ptr_q];

	a_resq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (RESQ_AW + 1)'(RESQ_DEPTH))
		else $error("result queue count over depth");

	a_sent_only_cell: assert property (@(posedge clk) disable iff (!arst_n)
		(evq_pop && sent) |-> (evq_head.kind == EV_CELL))
		else $error("request flagged on an event other than cell found");

	a_step_follows_state: assert property (@(posedge clk) disable iff (!arst_n)
		(evq_pop && evq_head.kind == EV_REQ && (cur_q.st == ST_DEREG || cur_q.st == ST_REGD))
		|=> (cur_q.st == ST_SEARCH && cur_q.step == STEP_CELL && cur_q.proc))
		else $error("request from idle state did not start the procedure");

endmodule

// ===== sim/registration_retry_state_machine_core_test.sv =====
// Self-checking testbench for registration_retry_state_machine_core.
// Depends on rrsm_pkg and the core; carries its own model of the controller,
// drives a directed table and then state-aware random events through the queues.
module registration_retry_state_machine_core_test;
	import rrsm_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 60;
	localparam logic [3:0] OP_UNUSED = 4'd15;
	localparam logic [2:0] RC_SPARE = 3'd7;
	localparam logic [NOW_W-1:0] NOW_MAX = '1;

	// numeric state codes as they appear on mm_state
	typedef enum logic [2:0] {
		MM_OFF, MM_SIMNR, MM_DEREG, MM_SEARCH, MM_REGING, MM_REGD
	} mm_code_t;

	typedef struct packed {
		logic [3:0]       op;
		logic             flag_on;
		logic             sim_in;
		logic             submitted;
		logic             non3gpp;
		logic [2:0]       rc;
		logic [NOW_W-1:0] at_ms;
	} ev_t;

	typedef struct packed {
		ev_t  ev;
		logic typed;
		res_t known;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic wr_en = 1'b0;
	logic wr_index = REG_RETRY_LIMIT;
	logic [15:0] wr_data = '0;
	logic push = 1'b0;
	logic full;
	logic [3:0] opcode = OP_INIT;
	logic flag_on = 1'b0;
	logic sim_in = 1'b0;
	logic was_submitted = 1'b0;
	logic accept_non3gpp = 1'b0;
	logic [2:0] rej_cause = RC_NONE;
	logic [NOW_W-1:0] now_ms = '0;
	logic empty;
	logic pop = 1'b0;
	logic [2:0] mm_state;
	logic in_procedure;
	logic [1:0] step_code;
	logic [3:0] trans_cause;
	logic reject_permanent;
	logic [3:0] retry_cnt;
	logic [15:0] attempt_number;
	logic request_pending;
	logic reg_kind;
	logic [1:0] reg_trigger;
	logic request_sent;

	// controller model state
	mm_code_t m_state = MM_OFF;
	logic proc_on = 1'b0;
	logic [1:0] step_now = STEP_NONE;
	cause_t cause_now = C_RADIO_OFF;
	logic perm_cls = 1'b0;
	logic [3:0] retries = '0;
	logic [15:0] attempts = '0;
	logic req_on = 1'b0;
	logic req_type = RT_INITIAL;
	logic [1:0] req_trig = TRIG_EXPLICIT;
	logic [TIME_BITS:0] deadline = '0;
	logic [3:0] cfg_retry_limit = RETRY_LIMIT_RST;
	logic [15:0] cfg_step_tmo = STEP_TMO_RST;

	res_t status_q[$];
	logic [NOW_W-1:0] clock_ms = '0;
	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	bit hold_req = 1'b0;
	int mismatches = 0;
	int quiet_cycles = 0;

	registration_retry_state_machine_core dut (.*);

	always #6 clk = ~clk;

	function automatic logic rc_permanent(input logic [2:0] rc);
		return (rc >= RC_ILLEGAL_UE) && (rc <= RC_TA_NA);
	endfunction

	function automatic void drop_to_dereg(input cause_t c);
		m_state = MM_DEREG;
		proc_on = 1'b0;
		step_now = STEP_NONE;
		cause_now = c;
		req_on = 1'b0;
		retries = '0;
		deadline = '0;
	endfunction

	function automatic void retry_again(input logic [TIME_BITS:0] next_deadline);
		retries = retries + 1'b1;
		attempts = attempts + 1'b1;
		m_state = MM_SEARCH;
		proc_on = 1'b1;
		step_now = STEP_CELL;
		cause_now = C_RETRY;
		perm_cls = 1'b0;
		deadline = next_deadline;
	endfunction

	function automatic void abort_procedure(input mm_code_t st, input cause_t c);
		m_state = st;
		proc_on = 1'b0;
		step_now = STEP_NONE;
		cause_now = c;
		perm_cls = 1'b0;
		req_on = 1'b0;
		retries = '0;
		deadline = '0;
	endfunction

	function automatic void start_request(input logic rtype, input logic [1:0] trig);
		req_on = 1'b1;
		retries = '0;
		req_type = rtype;
		req_trig = trig;
		if (m_state == MM_DEREG || m_state == MM_REGD) begin
			attempts = attempts + 1'b1;
			m_state = MM_SEARCH;
			proc_on = 1'b1;
			step_now = STEP_CELL;
			cause_now = C_REQUESTED;
			perm_cls = 1'b0;
			deadline = '0;
		end
	endfunction

	// arm on first tick, then retry or give up once the deadline is reached
	function automatic void check_deadline(input logic [NOW_W-1:0] at_ms);
		logic [TIME_BITS:0] t;
		t = {1'b0, at_ms[TIME_BITS-1:0]};
		if (deadline == '0)
			deadline = t + cfg_step_tmo;
		if (t >= deadline) begin
			if (retries < cfg_retry_limit) begin
				retry_again(t + cfg_step_tmo);
			end else begin
				drop_to_dereg(C_TIMEOUT);
				perm_cls = 1'b0;
			end
		end
	endfunction

	function automatic res_t next_status(input ev_t ev);
		res_t r;
		logic sent;
		sent = 1'b0;
		case (ev.op)
			OP_INIT: begin
				abort_procedure(MM_OFF, C_RADIO_OFF);
				req_type = RT_INITIAL;
				req_trig = TRIG_EXPLICIT;
				if (ev.flag_on) begin
					m_state = ev.sim_in ? MM_DEREG : MM_SIMNR;
					cause_now = ev.sim_in ? C_POWER_ON : C_SIM_NR;
				end
			end
			OP_RADIO: begin
				if (!ev.flag_on) begin
					abort_procedure(MM_OFF, C_RADIO_OFF);
				end else if (m_state != MM_SIMNR) begin
					drop_to_dereg(C_POWER_ON);
					perm_cls = 1'b0;
				end
			end
			OP_SIM: begin
				if (!ev.flag_on) begin
					abort_procedure(MM_SIMNR, C_SIM_NR);
				end else begin
					if (m_state == MM_SIMNR)
						m_state = MM_DEREG;
					cause_now = C_SIM_READY;
				end
			end
			OP_REG: start_request(RT_INITIAL, TRIG_EXPLICIT);
			OP_MOBILITY: start_request(RT_MOBILITY, TRIG_MOBILITY);
			OP_PERIODIC: start_request(RT_MOBILITY, TRIG_PERIODIC);
			OP_CELL: begin
				if (m_state == MM_SEARCH && req_on && step_now == STEP_CELL) begin
					sent = 1'b1;
					if (ev.submitted && !ev.non3gpp) begin
						perm_cls = 1'b0;
						m_state = MM_REGING;
						step_now = STEP_RESP;
						deadline = '0;
					end else begin
						// a non-3GPP accept counts as a permanent reject; an unsent request takes it from the cause
						perm_cls = ev.submitted ? 1'b1 : rc_permanent(ev.rc);
						drop_to_dereg(C_REJECTED);
					end
				end
			end
			OP_FORCE: begin
				m_state = MM_REGING;
				step_now = STEP_RESP;
				deadline = '0;
			end
			OP_ACCEPT: begin
				if (m_state == MM_REGING && req_on)
					abort_procedure(MM_REGD, C_ACCEPTED);
			end
			OP_REJECT: begin
				if (m_state == MM_REGING && req_on) begin
					perm_cls = rc_permanent(ev.rc);
					if (proc_on && step_now == STEP_RESP && !perm_cls &&
							retries < cfg_retry_limit)
						retry_again('0);
					else
						drop_to_dereg(C_REJECTED);
				end
			end
			OP_TICK: begin
				if ((m_state == MM_SEARCH && req_on && step_now == STEP_CELL) ||
						(m_state == MM_REGING && req_on && step_now == STEP_RESP)) begin
					check_deadline(ev.at_ms);
				end else begin
					if (m_state != MM_REGING && m_state != MM_SEARCH) begin
						proc_on = 1'b0;
						step_now = STEP_NONE;
					end
					deadline = '0;
				end
			end
			default: ;
		endcase
		r.mm_state = m_state;
		r.in_procedure = proc_on;
		r.step_code = step_now;
		r.trans_cause = cause_now;
		r.reject_permanent = perm_cls;
		r.retry_cnt = retries;
		r.attempt_number = attempts;
		r.request_pending = req_on;
		r.reg_kind = req_type;
		r.reg_trigger = req_trig;
		r.request_sent = sent;
		return r;
	endfunction

	function automatic ev_t ev_of(input logic [3:0] op, input logic on, input logic sim,
			input logic sub, input logic n3g, input logic [2:0] rc,
			input logic [NOW_W-1:0] at_ms);
		ev_t ev;
		ev.op = op;
		ev.flag_on = on;
		ev.sim_in = sim;
		ev.submitted = sub;
		ev.non3gpp = n3g;
		ev.rc = rc;
		ev.at_ms = at_ms;
		return ev;
	endfunction

	function automatic res_t status_of(input logic [2:0] mm, input logic proc,
			input logic [1:0] stp, input logic [3:0] cs, input logic perm,
			input logic [3:0] rt, input logic [15:0] att, input logic rq,
			input logic ty, input logic [1:0] tg, input logic sent);
		res_t r;
		r = '{mm, proc, stp, cs, perm, rt, att, rq, ty, tg, sent};
		return r;
	endfunction

	function automatic stim_row_t row_of(input ev_t ev, input logic typed, input res_t known);
		stim_row_t row;
		row.ev = ev;
		row.typed = typed;
		row.known = known;
		return row;
	endfunction

	// mostly events that make sense in the modeled state, the rest pure noise
	function automatic ev_t next_event();
		ev_t ev;
		int sel;
		ev.op = 4'($urandom_range(0, 15));
		ev.flag_on = 1'($urandom);
		ev.sim_in = 1'($urandom);
		ev.submitted = 1'($urandom);
		ev.non3gpp = 1'($urandom);
		ev.rc = 3'($urandom);
		ev.at_ms = {8'($urandom), 32'($urandom)};
		if ($urandom_range(0, 99) < 20)
			return ev;
		sel = $urandom_range(0, 99);
		ev.flag_on = 1'b1;
		ev.sim_in = ($urandom_range(0, 9) != 0);
		ev.submitted = ($urandom_range(0, 9) != 0);
		ev.non3gpp = ($urandom_range(0, 9) == 0);
		case (m_state)
			MM_OFF: ev.op = (sel < 75) ? OP_INIT : OP_RADIO;
			MM_SIMNR: ev.op = (sel < 60) ? OP_SIM : OP_REG;
			MM_SEARCH: ev.op = (sel < 45) ? OP_TICK : OP_CELL;
			MM_REGING: begin
				if (!req_on)
					ev.op = OP_REG;
				else if (sel < 35)
					ev.op = OP_ACCEPT;
				else if (sel < 70)
					ev.op = OP_REJECT;
				else
					ev.op = OP_TICK;
			end
			default: begin
				if (sel < 30) begin
					ev.op = OP_REG;
				end else if (sel < 55) begin
					ev.op = OP_MOBILITY;
				end else if (sel < 80) begin
					ev.op = OP_PERIODIC;
				end else if (sel < 88) begin
					ev.op = OP_TICK;
				end else if (sel < 94) begin
					ev.op = OP_FORCE;
				end else begin
					ev.op = OP_RADIO;
					ev.flag_on = 1'($urandom);
				end
			end
		endcase
		if (ev.op == OP_TICK) begin
			// step up to two timeouts plus one so deadlines both hold and expire
			clock_ms = clock_ms + $urandom_range(0, 2 * cfg_step_tmo + 1);
			ev.at_ms = clock_ms;
		end
		return ev;
	endfunction

	// offer one event until it is taken, then record its expected status
	task automatic offer(input ev_t ev, input logic typed, input res_t known);
		res_t predicted;
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		opcode <= ev.op;
		flag_on <= ev.flag_on;
		sim_in <= ev.sim_in;
		was_submitted <= ev.submitted;
		accept_non3gpp <= ev.non3gpp;
		rej_cause <= ev.rc;
		now_ms <= ev.at_ms;
		@(posedge clk);
		while (full)
			@(posedge clk);
		predicted = next_status(ev);
		status_q.push_back(typed ? known : predicted);
	endtask

	task automatic settle();
		push <= 1'b0;
		while (status_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_limits(input logic [3:0] limit, input logic [15:0] step_tmo);
		wr_en <= 1'b1;
		wr_index <= REG_RETRY_LIMIT;
		wr_data <= {12'd0, limit};
		@(posedge clk);
		wr_index <= REG_STEP_TMO;
		wr_data <= step_tmo;
		@(posedge clk);
		wr_en <= 1'b0;
		cfg_retry_limit = limit;
		cfg_step_tmo = step_tmo;
	endtask

	task automatic run_phase(input int count, input int tx_pct, input int rx_pct,
			input int pause_at);
		tx_idle_pct = tx_pct;
		rx_stall_pct = rx_pct;
		for (int i = 0; i < count; i++) begin
			// hold the sender until every outstanding status has come back
			if (i == pause_at) begin
				push <= 1'b0;
				while (status_q.size() != 0)
					@(posedge clk);
			end
			offer(next_event(), 1'b0, '0);
		end
	endtask

	initial begin : stimulus
		stim_row_t dir_rows[$];
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values in force: two retries, 1200 ms per step
		dir_rows.push_back(row_of(ev_of(OP_UNUSED, 1, 1, 1, 1, RC_SPARE, NOW_MAX), 1'b1,
			status_of(MM_OFF, 0, STEP_NONE, C_RADIO_OFF, 0, 0, 0, 0, RT_INITIAL,
				TRIG_EXPLICIT, 0)));
		dir_rows.push_back(row_of(ev_of(OP_INIT, 1, 1, 0, 0, RC_NONE, 0), 1'b1,
			status_of(MM_DEREG, 0, STEP_NONE, C_POWER_ON, 0, 0, 0, 0, RT_INITIAL,
				TRIG_EXPLICIT, 0)));
		dir_rows.push_back(row_of(ev_of(OP_REG, 0, 0, 0, 0, RC_NONE, 0), 1'b1,
			status_of(MM_SEARCH, 1, STEP_CELL, C_REQUESTED, 0, 0, 1, 1, RT_INITIAL,
				TRIG_EXPLICIT, 0)));
		dir_rows.push_back(row_of(ev_of(OP_TICK, 0, 0, 0, 0, RC_NONE, 0), 1'b0, '0));
		dir_rows.push_back(row_of(ev_of(OP_TICK, 0, 0, 0, 0, RC_NONE, 1200), 1'b0, '0));
		dir_rows.push_back(row_of(ev_of(OP_TICK, 0, 0, 0, 0, RC_NONE, 2400), 1'b0, '0));
		dir_rows.push_back(row_of(ev_of(OP_TICK, 0, 0, 0, 0, RC_NONE, 3600), 1'b1,
			status_of(MM_DEREG, 0, STEP_NONE, C_TIMEOUT, 0, 0, 3, 0, RT_INITIAL,
				TRIG_EXPLICIT, 0)));
		dir_rows.push_back(row_of(ev_of(OP_MOBILITY, 0, 0, 0, 0, RC_NONE, 0), 1'b0, '0));
		dir_rows.push_back(row_of(ev_of(OP_CELL, 0, 0, 1, 0, RC_NONE, 0), 1'b0, '0));
		dir_rows.push_back(row_of(ev_of(OP_REJECT, 0, 0, 0, 0, RC_CONGESTION, 0), 1'b0, '0));
		dir_rows.push_back(row_of(ev_of(OP_CELL, 0, 0, 1, 0, RC_NONE, 0), 1'b0, '0));
		dir_rows.push_back(row_of(ev_of(OP_REJECT, 0, 0, 0, 0, RC_ILLEGAL_UE, 0), 1'b1,
			status_of(MM_DEREG, 0, STEP_NONE, C_REJECTED, 1, 0, 5, 0, RT_MOBILITY,
				TRIG_MOBILITY, 0)));
		dir_rows.push_back(row_of(ev_of(OP_PERIODIC, 0, 0, 0, 0, RC_NONE, 0), 1'b0, '0));
		dir_rows.push_back(row_of(ev_of(OP_CELL, 0, 0, 1, 1, RC_NONE, 0), 1'b0, '0));
		dir_rows.push_back(row_of(ev_of(OP_REG, 0, 0, 0, 0, RC_NONE, 0), 1'b0, '0));
		dir_rows.push_back(row_of(ev_of(OP_CELL, 0, 0, 0, 0, RC_SPARE, 0), 1'b0, '0));
		dir_rows.push_back(row_of(ev_of(OP_REG, 0, 0, 0, 0, RC_NONE, 0), 1'b0, '0));
		dir_rows.push_back(row_of(ev_of(OP_CELL, 0, 0, 1, 0, RC_NONE, 0), 1'b0, '0));
		dir_rows.push_back(row_of(ev_of(OP_ACCEPT, 0, 0, 0, 0, RC_NONE, 0), 1'b0, '0));
		dir_rows.push_back(row_of(ev_of(OP_TICK, 0, 0, 0, 0, RC_NONE, NOW_MAX), 1'b0, '0));
		dir_rows.push_back(row_of(ev_of(OP_REG, 0, 0, 0, 0, RC_NONE, 0), 1'b0, '0));
		dir_rows.push_back(row_of(ev_of(OP_TICK, 0, 0, 0, 0, RC_NONE, NOW_MAX), 1'b0, '0));
		// forced registering with no procedure, then a temporary reject
		dir_rows.push_back(row_of(ev_of(OP_INIT, 1, 0, 0, 0, RC_NONE, 0), 1'b0, '0));
		dir_rows.push_back(row_of(ev_of(OP_REG, 0, 0, 0, 0, RC_NONE, 0), 1'b0, '0));
		dir_rows.push_back(row_of(ev_of(OP_FORCE, 0, 0, 0, 0, RC_NONE, 0), 1'b0, '0));
		dir_rows.push_back(row_of(ev_of(OP_REJECT, 0, 0, 0, 0, RC_CONGESTION, 0), 1'b0, '0));
		// SIM ready while powered off keeps the state
		dir_rows.push_back(row_of(ev_of(OP_RADIO, 0, 0, 0, 0, RC_NONE, 0), 1'b0, '0));
		dir_rows.push_back(row_of(ev_of(OP_SIM, 1, 1, 0, 0, RC_NONE, 0), 1'b0, '0));
		dir_rows.push_back(row_of(ev_of(OP_RADIO, 1, 0, 0, 0, RC_NONE, 0), 1'b0, '0));
		foreach (dir_rows[i])
			offer(dir_rows[i].ev, dir_rows[i].typed, dir_rows[i].known);
		settle();

		set_limits(4'd2, 16'd1200);
		clock_ms = '0;
		run_phase(110, 0, 0, -1);
		settle();
		set_limits(4'd0, 16'd1);
		clock_ms = {8'($urandom), 32'($urandom)};
		run_phase(110, 78, 0, -1);
		settle();
		set_limits(4'd15, 16'hFFFF);
		run_phase(110, 0, 78, -1);
		settle();
		// zero timeout: a deadline of zero reads as unarmed
		set_limits(4'd5, 16'd0);
		clock_ms = '0;
		run_phase(60, 15, 15, -1);
		settle();
		set_limits(4'd3, 16'd300);
		hold_req = 1'b1;
		run_phase(80, 0, 0, 40);
		settle();
		set_limits(4'd1, 16'd5000);
		clock_ms = NOW_MAX - 40'd20000;
		run_phase(100, 15, 15, -1);
		settle();

		if (mismatches == 0)
			$display("registration_retry_state_machine_core_test: done, clean");
		else
			$display("registration_retry_state_machine_core_test: done, errors");
		$finish;
	end

	always @(posedge clk) begin : drain_results
		res_t want;
		int hold_left;
		bit hold_taken;
		if (pop && !empty) begin
			if (status_q.size() == 0) begin
				$error("status transfer with no event waiting for it");
				mismatches++;
			end else begin
				want = status_q.pop_front();
				if (mm_state !== want.mm_state) begin
					$error("mm_state: expected %0d, got %0d", want.mm_state, mm_state);
					mismatches++;
				end
				if (in_procedure !== want.in_procedure) begin
					$error("in_procedure: expected %0d, got %0d", want.in_procedure,
						in_procedure);
					mismatches++;
				end
				if (step_code !== want.step_code) begin
					$error("step_code: expected %0d, got %0d", want.step_code, step_code);
					mismatches++;
				end
				if (trans_cause !== want.trans_cause) begin
					$error("trans_cause: expected %0d, got %0d", want.trans_cause,
						trans_cause);
					mismatches++;
				end
				if (reject_permanent !== want.reject_permanent) begin
					$error("reject_permanent: expected %0d, got %0d", want.reject_permanent,
						reject_permanent);
					mismatches++;
				end
				if (retry_cnt !== want.retry_cnt) begin
					$error("retry_cnt: expected %0d, got %0d", want.retry_cnt,
						retry_cnt);
					mismatches++;
				end
				if (attempt_number !== want.attempt_number) begin
					$error("attempt_number: expected %0d, got %0d", want.attempt_number,
						attempt_number);
					mismatches++;
				end
				if (request_pending !== want.request_pending) begin
					$error("request_pending: expected %0d, got %0d", want.request_pending,
						request_pending);
					mismatches++;
				end
				if (reg_kind !== want.reg_kind) begin
					$error("reg_kind: expected %0d, got %0d", want.reg_kind, reg_kind);
					mismatches++;
				end
				if (reg_trigger !== want.reg_trigger) begin
					$error("reg_trigger: expected %0d, got %0d", want.reg_trigger,
						reg_trigger);
					mismatches++;
				end
				if (request_sent !== want.request_sent) begin
					$error("request_sent: expected %0d, got %0d", want.request_sent,
						request_sent);
					mismatches++;
				end
			end
		end
		// one long hold so the queues fill and full backs up the sender
		if (hold_req && !hold_taken) begin
			hold_taken = 1'b1;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(0, 99) >= rx_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("registration_retry_state_machine_core_test: done, errors");
			$finish;
		end
	end

endmodule
